[design/aes_pkg.sv]
package aes_pkg;

  localparam int RoundCount = 10;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_item_t;

  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_index_t;

  // Forward S-box as a constant table.
  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Round constants for rounds 1 to 10.
  localparam logic [7:0] RCON [RoundCount] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit block sits at bits 127-8i down to 120-8i.
  function automatic logic [7:0] get_byte(input logic [127:0] w, input int i);
    get_byte = w[127 - 8*i -: 8];
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      r[127 - 8*i -: 8] = SBOX[get_byte(s, i)];
    end
    sub_bytes = r;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s);
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int rw = 0; rw < 4; rw++) begin
        r[127 - 8*(4*c + rw) -: 8] = get_byte(s, 4*((c + rw) % 4) + rw);
      end
    end
    shift_rows = r;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      r[127 - 32*c -: 8]      = a0 ^ all ^ xtime(a0 ^ a1);
      r[127 - 32*c - 8 -: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
      r[127 - 32*c - 16 -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      r[127 - 32*c - 24 -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_columns = r;
  endfunction

  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t;
    logic [127:0] r;
    t = {SBOX[get_byte(k, 13)] ^ rc, SBOX[get_byte(k, 14)],
         SBOX[get_byte(k, 15)], SBOX[get_byte(k, 12)]};
    r[127:96] = k[127:96] ^ t;
    r[95:64]  = k[95:64] ^ r[127:96];
    r[63:32]  = k[63:32] ^ r[95:64];
    r[31:0]   = k[31:0] ^ r[63:32];
    next_key = r;
  endfunction

endpackage

[design/aes128_block_encrypt.sv]
// AES-128 block encryption, fully unrolled round pipeline.
// Input channel (in_valid/in_ready/in_data) takes one 128-bit plaintext item;
// output channel (out_valid/out_ready/out_data) returns its ciphertext item.
// The key is written through the config channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data): index 0 holds key bytes 0..7, index 1 bytes 8..15;
// other indexes are ignored. Write the key only while the pipeline is empty.
// Stage 0 registers the initial AddRoundKey; stages 1 to 10 each register
// one full round with its on-the-fly round key. One item per cycle is taken
// while the receiver does not stall.
// The pipeline advances as a whole when the output stage is empty or being
// taken; if the receiver stalls, every stage holds and in_ready drops, so
// nothing is lost or repeated.
// Reset (rst, synchronous) clears all stage valid bits and the key to zero.
module aes128_block_encrypt (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  aes_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output aes_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [63:0]       cfg_data
);

  localparam int Stages = aes_pkg::RoundCount + 1;

  logic [127:0] key;
  logic [127:0] state [Stages];
  logic [127:0] rkey  [Stages];
  logic         vld   [Stages];
  logic         advance;

  assign cfg_ready = 1'b1;
  assign advance   = !vld[Stages-1] || out_ready;
  assign in_ready  = advance;

  // Key registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_valid) begin
      unique case (aes_pkg::reg_index_t'(cfg_index))
        aes_pkg::REG_KEY_HIGH: key[127:64] <= cfg_data;
        aes_pkg::REG_KEY_LOW:  key[63:0]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Stages; i++) vld[i] <= 1'b0;
    end else if (advance) begin
      vld[0] <= in_valid;
      for (int i = 1; i < Stages; i++) vld[i] <= vld[i-1];
    end
  end

  // Initial AddRoundKey, then one round per stage.
  always_ff @(posedge clk) begin
    if (advance) begin
      state[0] <= {in_data.plain_high, in_data.plain_low} ^ key;
      rkey[0]  <= key;
      for (int r = 1; r < Stages; r++) begin
        rkey[r]  <= aes_pkg::next_key(rkey[r-1], aes_pkg::RCON[r-1]);
        if (r == Stages - 1) begin
          state[r] <= aes_pkg::shift_rows(aes_pkg::sub_bytes(state[r-1]))
                      ^ aes_pkg::next_key(rkey[r-1], aes_pkg::RCON[r-1]);
        end else begin
          state[r] <= aes_pkg::mix_columns(aes_pkg::shift_rows(
                        aes_pkg::sub_bytes(state[r-1])))
                      ^ aes_pkg::next_key(rkey[r-1], aes_pkg::RCON[r-1]);
        end
      end
    end
  end

  assign out_valid = vld[Stages-1];
  assign out_data  = aes_pkg::out_item_t'(state[Stages-1]);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The input is never held off while the output stage is empty.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("pipeline stalled with empty output");

  // A result is presented only if a stage before it held an item.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vld[Stages-2]))
    else $error("result appeared without an item");

endmodule

[test/aes128_block_encrypt_checker.sv]
`timescale 1ns / 100ps

module aes128_block_encrypt_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  aes_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  aes_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_count
);

  logic [63:0]        key_hi_copy;
  logic [63:0]        key_lo_copy;
  aes_pkg::out_item_t cipher_queue[$];

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] gf_dbl(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_prod(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_dbl(a);
    end
    return acc;
  endfunction

  // S-box computed from the field inverse (a^254) and the affine map.
  function automatic logic [7:0] sbox_of(logic [7:0] a);
    logic [7:0] inv;
    logic [7:0] base;
    inv = 8'h01;
    base = a;
    for (int e = 254; e != 0; e >>= 1) begin
      if (e & 1) inv = gf_prod(inv, base);
      base = gf_prod(base, base);
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
           ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  // Full ten-round encryption of one block, bytes held as an array.
  function automatic aes_pkg::out_item_t encrypt_block(aes_pkg::in_item_t blk,
                                                       logic [63:0] kh,
                                                       logic [63:0] kl);
    logic [7:0] st [16];
    logic [7:0] rk [16];
    logic [7:0] tmp [16];
    logic [7:0] rc;
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] pt, key, res;
    aes_pkg::out_item_t r;
    pt = {blk.plain_high, blk.plain_low};
    key = {kh, kl};
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127 - 8*i -: 8];
      st[i] = pt[127 - 8*i -: 8] ^ rk[i];
    end
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int i = 0; i < 16; i++) st[i] = sbox_of(st[i]);
      for (int c = 0; c < 4; c++)
        for (int rw = 0; rw < 4; rw++) tmp[4*c + rw] = st[4*((c + rw) % 4) + rw];
      st = tmp;
      if (rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ all ^ gf_dbl(a0 ^ a1);
          st[4*c+1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
          st[4*c+2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
          st[4*c+3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
        end
      end
      // Next round key: rotate, substitute and add the round constant.
      tmp[0] = rk[0] ^ sbox_of(rk[13]) ^ rc;
      tmp[1] = rk[1] ^ sbox_of(rk[14]);
      tmp[2] = rk[2] ^ sbox_of(rk[15]);
      tmp[3] = rk[3] ^ sbox_of(rk[12]);
      for (int i = 4; i < 16; i++) tmp[i] = rk[i] ^ tmp[i - 4];
      rk = tmp;
      rc = gf_dbl(rc);
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = st[i];
    r.cipher_high = res[127:64];
    r.cipher_low = res[63:0];
    return r;
  endfunction

  assign pending_count = cipher_queue.size();

  // Track key writes, predict on accepted items, compare on results.
  always @(posedge clk) begin
    aes_pkg::out_item_t exp_item;
    int errs;
    errs = 0;
    if (rst) begin
      key_hi_copy <= '0;
      key_lo_copy <= '0;
      cipher_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == aes_pkg::REG_KEY_HIGH) key_hi_copy <= cfg_data;
        else key_lo_copy <= cfg_data;
      end
      if (in_valid && in_ready)
        cipher_queue.push_back(encrypt_block(in_data, key_hi_copy, key_lo_copy));
      if (out_valid && out_ready) begin
        if (cipher_queue.size() == 0) begin
          $display("%0t: unexpected item, actual %h", $time, out_data);
          errs++;
        end else begin
          exp_item = cipher_queue.pop_front();
          if (out_data.cipher_high !== exp_item.cipher_high) begin
            $display("%0t: cipher_high expected %h actual %h", $time,
                     exp_item.cipher_high, out_data.cipher_high);
            errs++;
          end
          if (out_data.cipher_low !== exp_item.cipher_low) begin
            $display("%0t: cipher_low expected %h actual %h", $time,
                     exp_item.cipher_low, out_data.cipher_low);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

[test/aes128_block_encrypt_tb.sv]
`timescale 1ns / 100ps

module aes128_block_encrypt_tb;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  aes_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  aes_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [0:0]         cfg_index;
  logic [63:0]        cfg_data;
  int                 fail_count;
  int                 pending_count;
  int                 send_idle_pct;
  int                 recv_idle_pct;

  aes128_block_encrypt i_dut (.*);

  aes128_block_encrypt_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_key(aes_pkg::reg_index_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Send one item, with random idle cycles before it.
  task automatic send_block(logic [63:0] hi, logic [63:0] lo);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{plain_high: hi, plain_low: lo};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random blocks, some with walking or saturated patterns.
  task automatic send_random(int count);
    logic [63:0] hi, lo;
    for (int n = 0; n < count; n++) begin
      hi = rand64();
      lo = rand64();
      case ($urandom_range(9))
        0: hi = '1;
        1: lo = '0;
        2: hi = 64'h1 << $urandom_range(63);
        default: ;
      endcase
      send_block(hi, lo);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = aes_pkg::REG_KEY_HIGH;
    cfg_data = '0;
    send_idle_pct = 6;
    recv_idle_pct = 50;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: all-zero key from reset, then field extremes.
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h8000000000000000, 64'h1);
    drain();
    // Standard test vector key.
    write_key(aes_pkg::REG_KEY_HIGH, 64'h2b7e151628aed2a6);
    write_key(aes_pkg::REG_KEY_LOW, 64'habf7158809cf4f3c);
    send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
    send_block(64'h00112233_44556677, 64'h8899aabb_ccddeeff);
    send_block('0, '1);
    send_block('1, '0);
    send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    // Hold off until everything has come back.
    drain();
    write_key(aes_pkg::REG_KEY_HIGH, '1);
    write_key(aes_pkg::REG_KEY_LOW, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_random(280);
    drain();

    send_idle_pct = 50;
    recv_idle_pct = 6;
    write_key(aes_pkg::REG_KEY_HIGH, '0);
    write_key(aes_pkg::REG_KEY_LOW, rand64());
    send_random(280);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_key(aes_pkg::REG_KEY_HIGH, rand64());
    write_key(aes_pkg::REG_KEY_LOW, rand64());
    send_random(280);
    drain();

    if (fail_count == 0) $display("[aes128_block_encrypt] OK");
    else $display("[aes128_block_encrypt] ERROR");
    $finish;
  end

  initial begin
    #2ms;
    $display("[aes128_block_encrypt] ERROR");
    $finish;
  end

endmodule
